@@ hdl/chtd_pkg.sv @@
`default_nettype none

package chtd_pkg;

    // sizes of the block
    localparam int ALPHABET_MAX  = 280;
    localparam int NODE_DEPTH    = 1024;
    localparam int MAX_CODE_BITS = 15;

    // field widths
    localparam int OP_W     = 2;
    localparam int STAT_W   = 2;
    localparam int SYM_W    = 9;
    localparam int LEN_W    = 4;
    localparam int CODE_W   = 16;
    localparam int HIST_W   = 9;
    localparam int LEN_VALS = 1 << LEN_W;

    // derived widths
    localparam int LEN_AW     = $clog2(ALPHABET_MAX);
    localparam int SYM_CNT_W  = $clog2(ALPHABET_MAX + 1);
    localparam int NODE_AW    = $clog2(NODE_DEPTH);
    localparam int NODE_CNT_W = $clog2(NODE_DEPTH + 1);

    localparam logic [SYM_W-1:0] ALPHABET_RESET = SYM_W'(280);

    // opcodes
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_BUILD  = 2'd1;
    localparam logic [OP_W-1:0] OP_DECODE = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] ST_SYMBOL     = 2'd0;
    localparam logic [STAT_W-1:0] ST_DEAD_END   = 2'd1;
    localparam logic [STAT_W-1:0] ST_BUILD_DONE = 2'd2;
    localparam logic [STAT_W-1:0] ST_OVERFLOW   = 2'd3;

    // one node table entry, child index 0 means no child
    typedef struct packed {
        logic               leaf;
        logic [SYM_W-1:0]   sym;
        logic [NODE_AW-1:0] left;
        logic [NODE_AW-1:0] right;
    } node_t;

    // control from the sequencer to the code table
    typedef struct packed {
        logic             clear;
        logic             count;
        logic             gen;
        logic             take;
        logic [LEN_W-1:0] len;
    } code_ctl_t;

endpackage

`default_nettype wire

@@ hdl/chtd_code_table.sv @@
`default_nettype none

module chtd_code_table (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire chtd_pkg::code_ctl_t          ctl,
    output logic                              gen_last,
    output logic [chtd_pkg::CODE_W-1:0]       code
);
    import chtd_pkg::*;

    logic [HIST_W-1:0] hist_reg     [LEN_VALS];
    logic [CODE_W-1:0] len_code_reg [LEN_VALS];
    logic [LEN_W-1:0]  b_reg;
    logic [LEN_W-1:0]  b_next;
    logic [CODE_W-1:0] code_reg;
    logic [CODE_W-1:0] code_next;
    logic [CODE_W-1:0] code_sum;

    // canonical first code for length b
    assign code_sum  = code_reg + CODE_W'(hist_reg[b_reg - LEN_W'(1)]);
    assign gen_last  = (b_reg == LEN_W'(LEN_VALS - 1));
    assign code      = len_code_reg[ctl.len];

    always_comb
    begin
        b_next    = b_reg;
        code_next = code_reg;
        if (ctl.clear)
        begin
            b_next    = LEN_W'(1);
            code_next = '0;
        end
        else if (ctl.gen)
        begin
            b_next    = b_reg + LEN_W'(1);
            code_next = {code_sum[CODE_W-2:0], 1'b0};
        end
    end

    // generation step counter and running code
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_reg    <= LEN_W'(1);
            code_reg <= '0;
        end
        else
        begin
            b_reg    <= b_next;
            code_reg <= code_next;
        end
    end

    // length histogram, wraps at its width
    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            for (int i = 0; i < LEN_VALS; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (ctl.count && ctl.len != '0)
        begin
            hist_reg[ctl.len] <= hist_reg[ctl.len] + HIST_W'(1);
        end
    end

    // running code per length, bumped as each symbol takes one
    always_ff @(posedge clk)
    begin
        if (ctl.gen)
        begin
            len_code_reg[b_reg] <= code_next;
        end
        else if (ctl.take)
        begin
            len_code_reg[ctl.len] <= len_code_reg[ctl.len] + CODE_W'(1);
        end
    end

endmodule

`default_nettype wire

@@ hdl/canonical_huffman_tree_decoder_top.sv @@
// Canonical Huffman decoder built on a node table.
// Input channel (in_valid/in_ready) carries one word per item: opcode with
// symbol_index/code_length for a length load, or stream_bit for a decode step.
// Output channel (out_valid/out_ready) carries status and symbol.
// The configuration register alphabet_in_use is written through cfg_write_en
// and cfg_write_data; the user must do so only while the block is idle, which
// the block itself does not enforce. Load: no result. Decode: one step per
// stream bit, reading the parent entry; a missing child ends it in a dead-end
// result, else it reads the child entry and ends in a symbol result at a leaf
// or moves the walk to that child. Parent and child are read one after other,
// as the node table has one synchronous read port. Build: histogram, first code
// per length, insertion walking each code, ending in build-done or overflow.
// Items are taken one at a time; in_ready is high only when no item is in work.
// A finished result waits in the output register while out_ready is low, and
// a following load or decode step is still accepted meanwhile; only an item
// that must deliver a result waits for the register to drain.
// Reset sets alphabet_in_use to 280, empties the tree (every decoded bit is a
// dead end until a build) and returns the walk to the root. No clearing pass.
`default_nettype none

module canonical_huffman_tree_decoder_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write_en,
    input  wire logic [chtd_pkg::SYM_W-1:0]    cfg_write_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [chtd_pkg::OP_W-1:0]     opcode,
    input  wire logic [chtd_pkg::SYM_W-1:0]    symbol_index,
    input  wire logic [chtd_pkg::LEN_W-1:0]    code_length,
    input  wire logic                          stream_bit,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [chtd_pkg::STAT_W-1:0]        status,
    output logic [chtd_pkg::SYM_W-1:0]         symbol
);
    import chtd_pkg::*;

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] S_IDLE    = 4'd0;
    localparam logic [ST_W-1:0] S_CNT_RD  = 4'd1;
    localparam logic [ST_W-1:0] S_CNT_UPD = 4'd2;
    localparam logic [ST_W-1:0] S_CODE    = 4'd3;
    localparam logic [ST_W-1:0] S_INS_RD  = 4'd4;
    localparam logic [ST_W-1:0] S_INS_LEN = 4'd5;
    localparam logic [ST_W-1:0] S_WALK_RD = 4'd6;
    localparam logic [ST_W-1:0] S_WALK_EX = 4'd7;
    localparam logic [ST_W-1:0] S_DEC_PAR = 4'd8;
    localparam logic [ST_W-1:0] S_DEC_CHD = 4'd9;

    // control and work registers
    logic [ST_W-1:0]       state_reg,      state_next;
    logic [SYM_W-1:0]      alphabet_reg,   alphabet_next;
    logic [SYM_CNT_W-1:0]  count_reg,      count_next;
    logic [SYM_CNT_W-1:0]  sidx_reg,       sidx_next;
    logic [NODE_CNT_W-1:0] nodes_used_reg, nodes_used_next;
    logic [NODE_AW-1:0]    walk_reg,       walk_next;
    logic [NODE_AW-1:0]    cur_reg,        cur_next;
    logic [NODE_AW-1:0]    child_reg,      child_next;
    logic                  fresh_reg,      fresh_next;
    logic                  tree_valid_reg, tree_valid_next;
    logic [LEN_W-1:0]      bit_reg,        bit_next;
    logic [CODE_W-1:0]     cword_reg,      cword_next;
    logic                  dec_bit_reg,    dec_bit_next;
    logic                  out_valid_reg,  out_valid_next;
    logic [STAT_W-1:0]     status_reg,     status_next;
    logic [SYM_W-1:0]      symbol_reg,     symbol_next;

    // length store
    logic [LEN_W-1:0]  len_mem [ALPHABET_MAX];
    logic [LEN_W-1:0]  len_rdata_reg;
    logic              len_we;
    logic              len_re;
    logic [LEN_W-1:0]  len_wdata;

    // node table
    node_t             node_mem [NODE_DEPTH];
    node_t             node_rdata_reg;
    logic              node_we;
    logic              node_re;
    logic [NODE_AW-1:0] node_waddr;
    logic [NODE_AW-1:0] node_raddr;
    node_t             node_wdata;

    // code table link
    code_ctl_t         ctl;
    logic              gen_last;
    logic [CODE_W-1:0] code;

    logic              out_free;
    node_t             entry_dec;
    node_t             entry_walk;
    logic              walk_dir;
    logic [NODE_AW-1:0] walk_child;
    logic [NODE_AW-1:0] dec_child;
    logic [SYM_CNT_W-1:0] count_init;

    chtd_code_table u_code_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .gen_last (gen_last),
        .code     (code)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign symbol    = symbol_reg;

    assign out_free   = !out_valid_reg || out_ready;
    assign entry_dec  = tree_valid_reg ? node_rdata_reg : '0;
    assign entry_walk = fresh_reg ? '0 : node_rdata_reg;
    assign walk_dir   = cword_reg[bit_reg - LEN_W'(1)];
    assign walk_child = walk_dir ? entry_walk.right : entry_walk.left;
    assign dec_child  = dec_bit_reg ? entry_dec.right : entry_dec.left;
    assign count_init = (int'(alphabet_reg) > ALPHABET_MAX) ? SYM_CNT_W'(ALPHABET_MAX)
                                                             : SYM_CNT_W'(alphabet_reg);
    assign len_wdata  = (int'(code_length) > MAX_CODE_BITS) ? LEN_W'(MAX_CODE_BITS)
                                                             : code_length;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        alphabet_next   = cfg_write_en ? cfg_write_data : alphabet_reg;
        count_next      = count_reg;
        sidx_next       = sidx_reg;
        nodes_used_next = nodes_used_reg;
        walk_next       = walk_reg;
        cur_next        = cur_reg;
        child_next      = child_reg;
        fresh_next      = fresh_reg;
        tree_valid_next = tree_valid_reg;
        bit_next        = bit_reg;
        cword_next      = cword_reg;
        dec_bit_next    = dec_bit_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        status_next     = status_reg;
        symbol_next     = symbol_reg;
        len_we          = 1'b0;
        len_re          = 1'b0;
        node_we         = 1'b0;
        node_re         = 1'b0;
        node_waddr      = cur_reg;
        node_raddr      = cur_reg;
        node_wdata      = entry_walk;
        ctl             = '0;
        ctl.len         = len_rdata_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (opcode)
                        OP_LOAD:
                        begin
                            len_we = (int'(symbol_index) < ALPHABET_MAX);
                        end
                        OP_BUILD:
                        begin
                            node_we         = 1'b1;
                            node_waddr      = '0;
                            node_wdata      = '0;
                            nodes_used_next = NODE_CNT_W'(1);
                            walk_next       = '0;
                            tree_valid_next = 1'b1;
                            sidx_next       = '0;
                            count_next      = count_init;
                            ctl.clear       = 1'b1;
                            state_next      = S_CNT_RD;
                        end
                        OP_DECODE:
                        begin
                            node_re      = 1'b1;
                            node_raddr   = walk_reg;
                            dec_bit_next = stream_bit;
                            state_next   = S_DEC_PAR;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // histogram pass
            S_CNT_RD:
            begin
                if (sidx_reg < count_reg)
                begin
                    len_re     = 1'b1;
                    state_next = S_CNT_UPD;
                end
                else
                begin
                    state_next = S_CODE;
                end
            end
            S_CNT_UPD:
            begin
                ctl.count  = 1'b1;
                sidx_next  = sidx_reg + SYM_CNT_W'(1);
                state_next = S_CNT_RD;
            end

            // first code of each length, one length per cycle
            S_CODE:
            begin
                ctl.gen = 1'b1;
                if (gen_last)
                begin
                    sidx_next  = '0;
                    state_next = S_INS_RD;
                end
            end

            // insertion pass
            S_INS_RD:
            begin
                if (sidx_reg < count_reg)
                begin
                    len_re     = 1'b1;
                    state_next = S_INS_LEN;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_BUILD_DONE;
                    symbol_next    = '0;
                    state_next     = S_IDLE;
                end
            end
            S_INS_LEN:
            begin
                if (len_rdata_reg == '0)
                begin
                    sidx_next  = sidx_reg + SYM_CNT_W'(1);
                    state_next = S_INS_RD;
                end
                else
                begin
                    ctl.take   = 1'b1;
                    cword_next = code;
                    bit_next   = len_rdata_reg;
                    cur_next   = '0;
                    fresh_next = 1'b0;
                    state_next = S_WALK_RD;
                end
            end
            S_WALK_RD:
            begin
                node_re    = 1'b1;
                node_raddr = cur_reg;
                state_next = S_WALK_EX;
            end
            S_WALK_EX:
            begin
                if (bit_reg == '0)
                begin
                    // end of the code: mark the leaf
                    node_we         = 1'b1;
                    node_wdata.leaf = 1'b1;
                    node_wdata.sym  = SYM_W'(sidx_reg);
                    sidx_next       = sidx_reg + SYM_CNT_W'(1);
                    state_next      = S_INS_RD;
                end
                else if (walk_child != '0)
                begin
                    cur_next   = walk_child;
                    fresh_next = 1'b0;
                    bit_next   = bit_reg - LEN_W'(1);
                    state_next = S_WALK_RD;
                end
                else if (nodes_used_reg == NODE_CNT_W'(NODE_DEPTH))
                begin
                    // a node linked just before the stop still holds old contents
                    node_we = fresh_reg;
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = ST_OVERFLOW;
                        symbol_next    = '0;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    // new child, known empty, so no read is needed for it
                    node_we = 1'b1;
                    if (walk_dir)
                    begin
                        node_wdata.right = nodes_used_reg[NODE_AW-1:0];
                    end
                    else
                    begin
                        node_wdata.left = nodes_used_reg[NODE_AW-1:0];
                    end
                    cur_next        = nodes_used_reg[NODE_AW-1:0];
                    nodes_used_next = nodes_used_reg + NODE_CNT_W'(1);
                    fresh_next      = 1'b1;
                    bit_next        = bit_reg - LEN_W'(1);
                    state_next      = S_WALK_EX;
                end
            end

            // decode step: parent entry, then child entry
            S_DEC_PAR:
            begin
                if (dec_child == '0)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = ST_DEAD_END;
                        symbol_next    = '0;
                        walk_next      = '0;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    node_re    = 1'b1;
                    node_raddr = dec_child;
                    child_next = dec_child;
                    state_next = S_DEC_CHD;
                end
            end
            S_DEC_CHD:
            begin
                if (node_rdata_reg.leaf)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = ST_SYMBOL;
                        symbol_next    = node_rdata_reg.sym;
                        walk_next      = '0;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    walk_next  = child_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            alphabet_reg   <= ALPHABET_RESET;
            count_reg      <= '0;
            sidx_reg       <= '0;
            nodes_used_reg <= NODE_CNT_W'(1);
            walk_reg       <= '0;
            cur_reg        <= '0;
            child_reg      <= '0;
            fresh_reg      <= 1'b0;
            tree_valid_reg <= 1'b0;
            bit_reg        <= '0;
            cword_reg      <= '0;
            dec_bit_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            status_reg     <= '0;
            symbol_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            alphabet_reg   <= alphabet_next;
            count_reg      <= count_next;
            sidx_reg       <= sidx_next;
            nodes_used_reg <= nodes_used_next;
            walk_reg       <= walk_next;
            cur_reg        <= cur_next;
            child_reg      <= child_next;
            fresh_reg      <= fresh_next;
            tree_valid_reg <= tree_valid_next;
            bit_reg        <= bit_next;
            cword_reg      <= cword_next;
            dec_bit_reg    <= dec_bit_next;
            out_valid_reg  <= out_valid_next;
            status_reg     <= status_next;
            symbol_reg     <= symbol_next;
        end
    end

    // length store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[symbol_index[LEN_AW-1:0]] <= len_wdata;
        end
        if (len_re)
        begin
            len_rdata_reg <= len_mem[sidx_reg[LEN_AW-1:0]];
        end
    end

    // node table, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_waddr] <= node_wdata;
        end
        if (node_re)
        begin
            node_rdata_reg <= node_mem[node_raddr];
        end
    end

endmodule

`default_nettype wire
